// ===== src/i2a_pkg.sv =====
// Shared types, constants and helper functions for the integer to decimal text converter.
package i2a_pkg;

    // Field widths of the request and result channels
    localparam int VALUE_W = 32;
    localparam int CODE_W  = 6;

    // Decimal digit store: ten BCD digits cover the full 32-bit magnitude
    localparam int MAG_W      = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int POS_W      = $clog2(NUM_DIGITS);

    // Shift-and-add-3 conversion: magnitude bits consumed per clock
    localparam int BITS_PER_STEP = 4;
    localparam int STEP_COUNT    = MAG_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(STEP_COUNT);

    // Depth of the queue between converter and emitter
    localparam int QUEUE_DEPTH = 2;

    // Character codes
    localparam logic [CODE_W-1:0] ASCII_ZERO  = CODE_W'(48);
    localparam logic [CODE_W-1:0] ASCII_NINE  = CODE_W'(57);
    localparam logic [CODE_W-1:0] ASCII_MINUS = CODE_W'(45);

    // One converted number waiting to be emitted
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } i2a_entry_t;

    // Converter states
    typedef enum logic [1:0] {
        FE_IDLE,
        FE_CONV,
        FE_PUSH
    } fe_state_t;

    // Emitter states
    typedef enum logic {
        BK_IDLE,
        BK_DIGIT
    } bk_state_t;

    // Position of the most significant nonzero digit (zero when all digits are zero)
    function automatic logic [POS_W-1:0] msd_index(input logic [BCD_W-1:0] bcd);
        logic [POS_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd[i*DIGIT_W +: DIGIT_W] != '0)
            begin
                idx = POS_W'(i);
            end
        end
        return idx;
    endfunction

    // ASCII code of the digit at a given position
    function automatic logic [CODE_W-1:0] digit_code(input logic [BCD_W-1:0] bcd,
                                                      input logic [POS_W-1:0] pos);
        logic [DIGIT_W-1:0] d;
        d = bcd[pos*DIGIT_W +: DIGIT_W];
        return ASCII_ZERO + CODE_W'(d);
    endfunction

endpackage

// ===== src/i2a_if.sv =====
// Valid/ready stream interfaces for the number request and character result channels.
interface i2a_num_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface i2a_text_if;
    logic       valid;
    logic       ready;
    logic [5:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ===== src/i2a_front.sv =====
// Front end: accepts a number, takes its sign and magnitude and converts it to BCD.
module i2a_front (
    input  logic              clk,
    input  logic              rst_n,
    i2a_num_if.sink           num,
    output logic              push_valid,
    input  logic              push_ready,
    output i2a_pkg::i2a_entry_t push_entry
);
    import i2a_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEP_COUNT - 1);

    fe_state_t          state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [MAG_W-1:0]   mag_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic               neg_reg;
    logic [MAG_W-1:0]   mag_in;
    logic [MAG_W-1:0]   mag_step;
    logic [BCD_W-1:0]   bcd_step;
    logic               accept;

    assign accept = num.valid && num.ready;

    // Take the magnitude in unsigned arithmetic, so the most negative value maps to 2^31
    assign mag_in = num.value[VALUE_W-1] ? (~num.value + MAG_W'(1)) : num.value;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FE_IDLE:
            begin
                if (num.valid)
                begin
                    state_next = FE_CONV;
                end
            end
            FE_CONV:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = FE_PUSH;
                end
            end
            FE_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = FE_IDLE;
                end
            end
            default:
            begin
                state_next = FE_IDLE;
            end
        endcase
    end

    // Outputs of the state machine
    always_comb
    begin
        num.ready  = (state_reg == FE_IDLE);
        push_valid = (state_reg == FE_PUSH);
        step_next  = (state_reg == FE_CONV) ? step_reg + STEP_W'(1) : '0;
    end

    // Run several shift-and-add-3 iterations per clock
    always_comb
    begin
        bcd_step = bcd_reg;
        mag_step = mag_reg;
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (bcd_step[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
                begin
                    bcd_step[d*DIGIT_W +: DIGIT_W] =
                        bcd_step[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
                end
            end
            {bcd_step, mag_step} = {bcd_step[BCD_W-2:0], mag_step, 1'b0};
        end
    end

    assign push_entry.neg = neg_reg;
    assign push_entry.bcd = bcd_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Load on accept, advance during conversion
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= num.value[VALUE_W-1];
            mag_reg <= mag_in;
            bcd_reg <= '0;
        end
        else if (state_reg == FE_CONV)
        begin
            mag_reg <= mag_step;
            bcd_reg <= bcd_step;
        end
    end

endmodule

// ===== src/i2a_queue.sv =====
// Short FIFO of converted numbers between the converter and the emitter.
module i2a_queue #(
    parameter int DEPTH = i2a_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  i2a_pkg::i2a_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output i2a_pkg::i2a_entry_t pop_entry
);
    import i2a_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    i2a_entry_t         slot_reg [DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_ready && pop_valid;
    assign pop_entry  = slot_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + IDX_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + IDX_W'(1);
            end
        end
    end

    // Store an incoming converted number
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/i2a_back.sv =====
// Back end: walks the BCD digits of a queued number and emits one character per cycle while the result side is ready.
module i2a_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  i2a_pkg::i2a_entry_t pop_entry,
    i2a_text_if.source          text
);
    import i2a_pkg::*;

    bk_state_t          state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [BCD_W-1:0]   bcd_reg;
    logic               out_valid_reg;
    logic [CODE_W-1:0]  char_reg;
    logic               last_reg;
    logic               advance;
    logic               emit;
    logic [CODE_W-1:0]  emit_code;
    logic               emit_last;
    logic [POS_W-1:0]   top;

    // Output register is free or being drained this cycle
    assign advance = !out_valid_reg || text.ready;
    assign top     = msd_index(pop_entry.bcd);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid && advance && (pop_entry.neg || top != '0))
                begin
                    state_next = BK_DIGIT;
                end
            end
            BK_DIGIT:
            begin
                if (advance && pos_reg == '0)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Character selection and digit position
    always_comb
    begin
        pop_ready = 1'b0;
        emit      = 1'b0;
        emit_code = ASCII_ZERO;
        emit_last = 1'b0;
        pos_next  = pos_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid && advance)
                begin
                    pop_ready = 1'b1;
                    emit      = 1'b1;
                    if (pop_entry.neg)
                    begin
                        emit_code = ASCII_MINUS;
                        pos_next  = top;
                    end
                    else
                    begin
                        emit_code = digit_code(pop_entry.bcd, top);
                        emit_last = (top == '0);
                        pos_next  = top - POS_W'(1);
                    end
                end
            end
            BK_DIGIT:
            begin
                if (advance)
                begin
                    emit      = 1'b1;
                    emit_code = digit_code(bcd_reg, pos_reg);
                    emit_last = (pos_reg == '0);
                    pos_next  = pos_reg - POS_W'(1);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign text.valid     = out_valid_reg;
    assign text.char_code = char_reg;
    assign text.is_last   = last_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (text.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the digits of the number being emitted; load the output register
    always_ff @(posedge clk)
    begin
        if (pop_ready)
        begin
            bcd_reg <= pop_entry.bcd;
        end
        if (emit)
        begin
            char_reg <= emit_code;
            last_reg <= emit_last;
        end
    end

endmodule

// ===== src/int32_to_decimal_ascii.sv =====
// Top level: signed 32-bit integer to decimal ASCII text, one character per result.
// The request is accepted, converted to BCD 4 bits at a time and pushed into the queue; the
// back end pops it and loads each character into the output register.
// Throughput: one character per cycle while the result side is ready; a number has 1 to 11
// characters. Numbers are paced by the BCD converter, one at a time, or by the result port.
// Reset clears all control state at once; there is no clearing pass.
module int32_to_decimal_ascii #(
    parameter int QUEUE_DEPTH = i2a_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    i2a_num_if.sink     num,
    i2a_text_if.source  text
);
    import i2a_pkg::*;

    logic       push_valid, push_ready;
    logic       pop_valid, pop_ready;
    i2a_entry_t push_entry, pop_entry;

    // Accept and convert
    i2a_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .num        (num),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // Decouple converter and emitter
    i2a_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // Emit characters
    i2a_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .text      (text)
    );

endmodule

// ===== src/i2a_checker.sv =====
// Port-level checker for the character result stream, bound to the top level.
module i2a_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [5:0] char_code,
    input logic       is_last
);
    import i2a_pkg::*;

    logic first_reg;
    logic lead_reg;
    logic accept;

    assign accept = valid && ready;

    // Track the start of each number and the position right after its sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            lead_reg  <= 1'b1;
        end
        else if (accept)
        begin
            first_reg <= is_last;
            lead_reg  <= is_last || (char_code == ASCII_MINUS);
        end
    end

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(char_code) && $stable(is_last))
        else $error("result changed while stalled");

    // Only a minus sign or a decimal digit
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (char_code == ASCII_MINUS)
                  || (char_code >= ASCII_ZERO && char_code <= ASCII_NINE))
        else $error("character code out of range");

    // A minus sign opens a number and never ends it
    a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
        valid && char_code == ASCII_MINUS |-> first_reg && !is_last)
        else $error("minus sign out of place");

    // No leading zero
    a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && lead_reg && char_code == ASCII_ZERO |-> is_last && first_reg)
        else $error("leading zero emitted");

endmodule

bind int32_to_decimal_ascii i2a_checker u_i2a_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (text.valid),
    .ready     (text.ready),
    .char_code (text.char_code),
    .is_last   (text.is_last)
);

// ===== dv/tb_int32_to_decimal_ascii.sv =====
// Testbench for int32_to_decimal_ascii: random and directed numbers, checked against a text predictor.
`timescale 1ns / 1ps

module tb_int32_to_decimal_ascii;
    import i2a_pkg::*;

    // One pending number request; drain_first holds it back until all text is out
    typedef struct {
        logic signed [31:0] value;
        bit                 drain_first;
    } num_req_t;

    // One expected character of the decimal text
    typedef struct {
        logic [CODE_W-1:0] char_code;
        logic              is_last;
    } text_char_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    i2a_num_if  num_ch ();
    i2a_text_if text_ch ();

    num_req_t   pending_reqs[$];
    text_char_t expected_chars[$];

    int requests_sent = 0;
    int requests_accepted = 0;
    int chars_checked = 0;
    int mismatches = 0;
    int n_negative = 0;
    int n_full_width = 0;
    int n_drains = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_gap = 0;
    int recv_gap = 0;

    int32_to_decimal_ascii DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .num   (num_ch),
        .text  (text_ch)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Log one mismatch; keep the log short if many fail
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 20)
        begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    // Work out the characters of one number and append them to the expected text
    function automatic void predict_chars(input logic signed [31:0] value);
        logic [31:0] mag;
        logic [3:0]  digs [10];
        int          n_digits;
        int          total;
        int          pos;
        text_char_t  c;
        mag = value[31] ? (32'd0 - value) : value;
        n_digits = 0;
        do
        begin
            digs[n_digits] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            n_digits++;
        end
        while (mag != 32'd0);
        total = n_digits + (value[31] ? 1 : 0);
        pos = 0;
        if (value[31])
        begin
            c.char_code = ASCII_MINUS;
            c.is_last = 1'b0;
            expected_chars.push_back(c);
            pos++;
            n_negative++;
        end
        for (int i = n_digits - 1; i >= 0; i--)
        begin
            c.char_code = ASCII_ZERO + CODE_W'(digs[i]);
            c.is_last = (pos == total - 1);
            expected_chars.push_back(c);
            pos++;
        end
        if (total == 11)
        begin
            n_full_width++;
        end
    endfunction

    // Queue one request
    task automatic push_num(input logic signed [31:0] value, input bit drain_first);
        num_req_t r;
        r.value = value;
        r.drain_first = drain_first;
        pending_reqs.push_back(r);
    endtask

    // Queue random numbers spread over all decimal lengths, with some near powers of ten
    task automatic push_random(input int count, input int drain_pct);
        int     kind;
        int     d;
        longint lim;
        longint v;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 2)
            begin
                v = longint'($urandom);
            end
            else
            begin
                lim = 1;
                if (kind < 4)
                begin
                    d = $urandom_range(0, 9);
                    repeat (d) lim = lim * 10;
                    v = lim + $urandom_range(0, 2) - 1;
                end
                else
                begin
                    d = $urandom_range(1, 10);
                    repeat (d) lim = lim * 10;
                    v = (longint'($urandom) * 4 + $urandom_range(0, 3)) % lim;
                    if (v > 64'sd2147483647)
                    begin
                        v = v % 64'sd2147483648;
                    end
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    v = -v;
                end
            end
            push_num(32'(v), $urandom_range(0, 99) < drain_pct);
        end
    endtask

    // Hold until the driver has handed over every queued request
    task automatic wait_queue_empty();
        while (pending_reqs.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Request driver: present queued numbers at the falling edge, with idle bursts
    always @(negedge clk)
    begin
        if (rst_n && !(num_ch.valid && requests_accepted != requests_sent))
        begin
            if (send_gap != 0)
            begin
                num_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain_first && expected_chars.size() != 0))
            begin
                num_ch.valid <= 1'b1;
                num_ch.value <= pending_reqs[0].value;
                if (pending_reqs[0].drain_first)
                begin
                    n_drains++;
                end
                void'(pending_reqs.pop_front());
                requests_sent++;
                send_gap <= ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
            end
            else
            begin
                num_ch.valid <= 1'b0;
            end
        end
    end

    // Result side: drop ready in random bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_gap != 0)
            begin
                text_ch.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if ($urandom_range(0, 99) < recv_idle_pct)
            begin
                text_ch.ready <= 1'b0;
                recv_gap <= $urandom_range(0, 4);
            end
            else
            begin
                text_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: check each accepted character, then predict each accepted request
    always @(posedge clk)
    begin : result_monitor
        text_char_t want;
        if (rst_n)
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character code %0d last %0b",
                                              text_ch.char_code, text_ch.is_last));
                end
                else
                begin
                    want = expected_chars.pop_front();
                    chars_checked++;
                    if (text_ch.char_code !== want.char_code)
                    begin
                        report_mismatch($sformatf("char_code %0d, expected %0d",
                                                  text_ch.char_code, want.char_code));
                    end
                    if (text_ch.is_last !== want.is_last)
                    begin
                        report_mismatch($sformatf("is_last %0b, expected %0b (char %0d)",
                                                  text_ch.is_last, want.is_last,
                                                  want.char_code));
                    end
                end
            end
            if (num_ch.valid && num_ch.ready)
            begin
                predict_chars(num_ch.value);
                requests_accepted++;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        num_ch.valid = 1'b0;
        num_ch.value = '0;
        text_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero, single digits, powers of ten, both extremes, bit patterns
        send_idle_pct = 30;
        recv_idle_pct = 30;
        push_num(32'sd0, 1'b0);
        push_num(32'sd1, 1'b0);
        push_num(-32'sd1, 1'b0);
        push_num(32'sd9, 1'b0);
        push_num(-32'sd9, 1'b0);
        push_num(32'sd10, 1'b0);
        push_num(-32'sd10, 1'b0);
        push_num(32'sd99, 1'b0);
        push_num(32'sd100, 1'b0);
        push_num(32'sd2147483647, 1'b0);
        push_num(32'h8000_0000, 1'b0);
        push_num(-32'sd2147483647, 1'b0);
        push_num(32'sd1000000000, 1'b0);
        push_num(32'sd999999999, 1'b0);
        push_num(-32'sd1000000000, 1'b0);
        push_num(-32'sd999999999, 1'b0);
        push_num(32'sd123456789, 1'b0);
        push_num(-32'sd123456789, 1'b0);
        push_num(32'h5555_5555, 1'b0);
        push_num(32'hAAAA_AAAA, 1'b0);
        push_num(32'h0F0F_0F0F, 1'b0);
        push_num(32'hF0F0_F0F0, 1'b0);
        wait_queue_empty();

        // Random with moderate idling on both sides
        send_idle_pct = 25;
        recv_idle_pct = 25;
        push_random(150, 2);
        wait_queue_empty();

        // Start with a full drain, then run back to back with no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(1, 100);
        push_random(99, 0);
        wait_queue_empty();

        // Heavy idling
        send_idle_pct = 60;
        recv_idle_pct = 60;
        push_random(60, 5);
        wait_queue_empty();

        // Final stretch without idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(45, 0);
        wait_queue_empty();

        while (requests_accepted != requests_sent || expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (expected_chars.size() != 0)
        begin
            report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
        end

        $display("Converted %0d numbers (%0d negative, %0d of eleven characters),",
                 requests_accepted, n_negative, n_full_width);
        $display("checked %0d characters, %0d full drains, %0d mismatches.",
                 chars_checked, n_drains, mismatches);
        if (mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d requests sent, %0d characters still expected",
                 requests_sent, expected_chars.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
